// ===== src/smq_pkg.sv =====
// Shared types and codes for the sorted multiset queue.
package smq_pkg;

   localparam int unsigned CapacityDefault = 16;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned EntriesWidth = 5;
   localparam int unsigned StatusWidth = 2;

   typedef logic signed [ValueWidth-1:0] value_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   // Broadcast from the top level to every cell in the row.
   typedef struct packed {
      logic      insert_en;
      logic      delete_en;
      logic      is_insert;
      value_type value;
   } cmd_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic      valid;
      logic      keep;
      value_type value;
   } link_type;

endpackage

// ===== src/smq_if.sv =====
// Request and response channel interfaces of the sorted multiset queue.
interface smq_req_if;
   logic                valid;
   logic                ready;
   smq_pkg::op_type     op;
   smq_pkg::value_type  value;

   modport source(output valid, output op, output value, input ready);
   modport sink(input valid, input op, input value, output ready);
endinterface

interface smq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   smq_pkg::value_type                    smallest;
   smq_pkg::value_type                    largest;
   logic [smq_pkg::EntriesWidth-1:0]      entries;
   logic                                  is_empty;
   logic [smq_pkg::StatusWidth-1:0]       status;

   modport source(output valid, output smallest, output largest, output entries,
                  output is_empty, output status, input ready);
   modport sink(input valid, input smallest, input largest, input entries,
                input is_empty, input status, output ready);
endinterface

// ===== src/smq_cell.sv =====
// One compare-and-shift cell of the sorted row.
module smq_cell (
   input  logic               clock,
   input  logic               reset,
   input  smq_pkg::cmd_type   cmd,
   input  smq_pkg::link_type  from_left,
   input  smq_pkg::link_type  from_right,
   output smq_pkg::link_type  link_out,
   output logic               match,
   output smq_pkg::value_type last_value
);

   logic               valid_ff, valid_in;
   smq_pkg::value_type value_ff, value_in;
   logic               le, lt;

   assign le = valid_ff && (value_ff <= cmd.value);
   assign lt = valid_ff && (value_ff < cmd.value);

   // Insert goes after equal values; delete stops at the first equal one.
   assign link_out.keep  = cmd.is_insert ? le : lt;
   assign link_out.valid = valid_ff;
   assign link_out.value = value_ff;

   assign match      = valid_ff && (value_ff == cmd.value);
   assign last_value = (valid_ff && !from_right.valid) ? value_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.insert_en && !le) begin
         valid_in = valid_ff | from_left.valid;
         value_in = from_left.keep ? cmd.value : from_left.value;
      end else if (cmd.delete_en && !lt) begin
         valid_in = from_right.valid;
         value_in = from_right.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

// ===== src/sorted_multiset_queue_top.sv =====
// Top level of the sorted multiset queue: cell row, count and response register.
//
//   channel  dir  payload                                       transfer when
//   req_ch   in   op, value                                     valid && ready
//   rsp_ch   out  smallest, largest, entries, is_empty, status  valid && ready
//
// An item updates the whole cell row at the edge it transfers; pending_ff then
// marks it, and its response is registered once the response slot is free, so
// one item per cycle is sustained while rsp_ch is not stalled.
// Reset empties the row at once; cell contents are not cleared.
// A stalled response holds one finished item in flight, then req_ch.ready drops.
module sorted_multiset_queue_top #(
   parameter int unsigned CAPACITY = smq_pkg::CapacityDefault
) (
   input  logic  clock,
   input  logic  reset,
   smq_req_if.sink   req_ch,
   smq_rsp_if.source rsp_ch
);

   localparam int unsigned CountWidth = $clog2(CAPACITY + 1);

   smq_pkg::cmd_type   cmd;
   smq_pkg::link_type  links [CAPACITY];
   smq_pkg::link_type  left_in [CAPACITY];
   smq_pkg::link_type  right_in [CAPACITY];
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] valid_vec;
   smq_pkg::value_type last_vals [CAPACITY];
   smq_pkg::value_type largest_now;

   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   pending_ff;
   smq_pkg::status_type    status_ff, status_in;
   logic                   rsp_valid_ff;
   smq_pkg::value_type     smallest_ff, largest_ff;
   logic [smq_pkg::EntriesWidth-1:0] entries_ff;
   logic                   is_empty_ff;
   smq_pkg::status_type    rsp_status_ff;

   logic accept, full, found, slot_free;

   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !pending_ff || slot_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CountWidth'(CAPACITY));
   assign found        = |match_vec;

   assign cmd.is_insert = (req_ch.op == smq_pkg::OP_INSERT);
   assign cmd.value     = req_ch.value;
   assign cmd.insert_en = accept && cmd.is_insert && !full;
   assign cmd.delete_en = accept && !cmd.is_insert && found;

   always_comb begin
      count_in  = count_ff;
      status_in = smq_pkg::ST_DONE;
      if (cmd.insert_en) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.delete_en) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.is_insert && full) begin
         status_in = smq_pkg::ST_FULL;
      end else if (!cmd.is_insert && !found) begin
         status_in = smq_pkg::ST_MISSING;
      end
   end

   // Neighbor wiring: the head sees a kept, valid left edge so it takes the value.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) begin
            left_in[i] = '{valid: 1'b1, keep: 1'b1, value: '0};
         end else begin
            left_in[i] = links[i-1];
         end
         if (i == CAPACITY - 1) begin
            right_in[i] = '{valid: 1'b0, keep: 1'b0, value: '0};
         end else begin
            right_in[i] = links[i+1];
         end
         valid_vec[i] = links[i].valid;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      smq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .from_left  (left_in[g]),
         .from_right (right_in[g]),
         .link_out   (links[g]),
         .match      (match_vec[g]),
         .last_value (last_vals[g])
      );
   end

   // Only the last valid cell drives a nonzero value.
   always_comb begin
      largest_now = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         largest_now = largest_now | last_vals[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            pending_ff <= 1'b1;
         end else if (slot_free) begin
            pending_ff <= 1'b0;
         end
         if (pending_ff && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff <= status_in;
      end
      if (pending_ff && slot_free) begin
         smallest_ff   <= links[0].valid ? links[0].value : '0;
         largest_ff    <= largest_now;
         entries_ff    <= smq_pkg::EntriesWidth'(count_ff);
         is_empty_ff   <= (count_ff == '0);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.smallest = smallest_ff;
   assign rsp_ch.largest  = largest_ff;
   assign rsp_ch.entries  = entries_ff;
   assign rsp_ch.is_empty = is_empty_ff;
   assign rsp_ch.status   = rsp_status_ff;

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == count_ff)
      else $error("count differs from number of occupied cells");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + 1'b1) & valid_vec) == '0)
      else $error("occupied cells are not a prefix of the row");

   a_full_flagged: assert property (@(posedge clock) disable iff (reset)
      accept && cmd.is_insert && full |=> status_ff == smq_pkg::ST_FULL)
      else $error("insert into full row not flagged");

   a_count_steady_on_miss: assert property (@(posedge clock) disable iff (reset)
      accept && !cmd.is_insert && !found |=> $stable(count_ff))
      else $error("failed delete changed the count");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sorted_multiset_queue_top: directed and random insert/delete traffic.
`timescale 1ns / 1ps

module testbench;

   localparam smq_pkg::value_type ValueMin = 32'sh8000_0000;
   localparam smq_pkg::value_type ValueMax = 32'sh7fff_ffff;

   typedef struct packed {
      smq_pkg::value_type                smallest;
      smq_pkg::value_type                largest;
      logic [smq_pkg::EntriesWidth-1:0]  entries;
      logic                              is_empty;
      logic [smq_pkg::StatusWidth-1:0]   status;
   } queue_summary_type;

   // Mirrors the sorted store and queues the summary each request should produce.
   class multiset_tracker_type;
      smq_pkg::value_type held[$];
      queue_summary_type  summaries[$];
      int                 failures = 0;

      function void note_request(smq_pkg::op_type op, smq_pkg::value_type v);
         int                pos;
         queue_summary_type s;
         pos = 0;
         s.status = smq_pkg::ST_DONE;
         if (op == smq_pkg::OP_INSERT) begin
            if (held.size() >= smq_pkg::CapacityDefault) begin
               s.status = smq_pkg::ST_FULL;
            end else begin
               // new value goes after any equal ones
               while (pos < held.size() && held[pos] <= v) pos++;
               held.insert(pos, v);
            end
         end else begin
            while (pos < held.size() && held[pos] < v) pos++;
            if (pos < held.size() && held[pos] == v) begin
               held.delete(pos);
            end else begin
               s.status = smq_pkg::ST_MISSING;
            end
         end
         s.entries  = smq_pkg::EntriesWidth'(held.size());
         s.is_empty = (held.size() == 0);
         s.smallest = (held.size() == 0) ? '0 : held[0];
         s.largest  = (held.size() == 0) ? '0 : held[held.size()-1];
         summaries.push_back(s);
      endfunction

      function void mismatch(string field, logic signed [63:0] want, logic signed [63:0] got);
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         failures++;
      endfunction

      function void check_response(queue_summary_type got);
         queue_summary_type want;
         if (summaries.size() == 0) begin
            $display("%0t: response transfer with no request outstanding", $time);
            failures++;
            return;
         end
         want = summaries.pop_front();
         if (got.smallest !== want.smallest) mismatch("smallest", want.smallest, got.smallest);
         if (got.largest !== want.largest) mismatch("largest", want.largest, got.largest);
         if (got.entries !== want.entries) mismatch("entries", want.entries, got.entries);
         if (got.is_empty !== want.is_empty) mismatch("is_empty", want.is_empty, got.is_empty);
         if (got.status !== want.status) mismatch("status", want.status, got.status);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   req_quiet = 1'b0;
   bit   rsp_quiet = 1'b0;

   multiset_tracker_type tracker = new;

   smq_req_if req_ch();
   smq_rsp_if rsp_ch();

   sorted_multiset_queue_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int draw_wait(bit quiet);
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   // Leaves the item driven; the caller either sends again or lowers valid.
   task automatic send_item(smq_pkg::op_type op, smq_pkg::value_type v);
      int gap;
      gap = draw_wait(req_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(op, v);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (tracker.summaries.size() > 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_response('{smallest: rsp_ch.smallest, largest: rsp_ch.largest,
                                  entries: rsp_ch.entries, is_empty: rsp_ch.is_empty,
                                  status: rsp_ch.status});
      end
   end

   // Response side: random stall before each transfer unless rsp_quiet is set.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = draw_wait(rsp_quiet);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   initial begin
      smq_pkg::value_type fill_set[15];
      smq_pkg::op_type    op;
      smq_pkg::value_type v;
      int                 bias;
      int                 insert_pct;
      int                 roll;

      fill_set = '{32'sh5555_5555, 32'shAAAA_AAAA, -1, 1, 0, 0, ValueMin, ValueMax,
                   100, -100, 100, 7, 7, -7, 42};
      req_ch.valid = 1'b0;
      req_ch.op    = smq_pkg::OP_INSERT;
      req_ch.value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty store, extremes, duplicates, full store, absent values
      send_item(smq_pkg::OP_DELETE, 0);
      send_item(smq_pkg::OP_INSERT, 0);
      send_item(smq_pkg::OP_INSERT, ValueMin);
      send_item(smq_pkg::OP_INSERT, ValueMax);
      send_item(smq_pkg::OP_INSERT, 0);
      send_item(smq_pkg::OP_DELETE, 7);
      send_item(smq_pkg::OP_DELETE, 0);
      send_item(smq_pkg::OP_DELETE, ValueMax);
      send_item(smq_pkg::OP_DELETE, ValueMin);
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      foreach (fill_set[i]) send_item(smq_pkg::OP_INSERT, fill_set[i]);
      send_item(smq_pkg::OP_INSERT, 3);
      send_item(smq_pkg::OP_DELETE, 12345);

      // random: blocks that lean toward filling, draining or neither
      for (int blk = 0; blk < 15; blk++) begin
         bias = $urandom_range(0, 2);
         insert_pct = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 30; k++) begin
            op = ($urandom_range(0, 99) < insert_pct) ? smq_pkg::OP_INSERT
                                                      : smq_pkg::OP_DELETE;
            roll = $urandom_range(0, 9);
            if (op == smq_pkg::OP_DELETE && roll < 7 && tracker.held.size() > 0) begin
               v = tracker.held[$urandom_range(0, tracker.held.size() - 1)];
            end else begin
               case ($urandom_range(0, 3))
                  0: v = $urandom_range(0, 6) - 3;
                  1: v = $urandom;
                  2: v = roll[0] ? ValueMin + $urandom_range(0, 2)
                                 : ValueMax - $urandom_range(0, 2);
                  default: v = (tracker.held.size() > 0)
                                  ? tracker.held[$urandom_range(0, tracker.held.size() - 1)]
                                  : $urandom;
               endcase
            end
            send_item(op, v);
         end
         if (blk == 6) begin
            release_request();
            wait_drained();
         end
      end

      release_request();
      wait_drained();
      repeat (8) @(posedge clock);
      if (tracker.failures == 0 && tracker.summaries.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sorted_multiset_queue_top.f =====
src/smq_pkg.sv
src/smq_if.sv
src/smq_cell.sv
src/sorted_multiset_queue_top.sv
tb/testbench.sv
